// ===== src/bht_pkg.sv =====
package bht_pkg;

    localparam int MAX_BONES_DEF = 256;

    // configuration port
    localparam int NUM_CFG   = 8;
    localparam int CFG_IDX_W = 4;

    localparam logic [63:0] PRE_RESET [NUM_CFG] = '{
        64'h0000_0000_3F80_0000, 64'h0000_0000_0000_0000,
        64'h3F80_0000_0000_0000, 64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000, 64'h0000_0000_3F80_0000,
        64'h0000_0000_0000_0000, 64'h3F80_0000_0000_0000
    };

    // float32 constants
    localparam logic [31:0] F32_ONE   = 32'h3F80_0000;
    localparam logic [31:0] F32_QNAN  = 32'hFFC0_0000;
    localparam logic [30:0] F32_INF   = 31'h7F80_0000;
    localparam logic [31:0] F32_QUIET = 32'h0040_0000;

    localparam int FPU_LATENCY = 3;

    typedef enum logic [1:0] {
        FOP_MUL = 2'd0,
        FOP_ADD = 2'd1,
        FOP_SUB = 2'd2
    } t_fop;

    typedef struct packed {
        logic        start;
        t_fop        op;
        logic [31:0] a;
        logic [31:0] b;
    } t_fpu_req;

endpackage

// ===== src/bht_if.sv =====
interface bht_in_if;
    logic              valid;
    logic              ready;
    logic [7:0]        bone_slot;
    logic signed [8:0] parent_slot;
    logic [63:0]       local_row0_lo;
    logic [63:0]       local_row0_hi;
    logic [63:0]       local_row1_lo;
    logic [63:0]       local_row1_hi;
    logic [63:0]       local_row2_lo;
    logic [63:0]       local_row2_hi;
    logic [63:0]       local_row3_lo;
    logic [63:0]       local_row3_hi;

    modport source (
        output valid, bone_slot, parent_slot,
               local_row0_lo, local_row0_hi, local_row1_lo, local_row1_hi,
               local_row2_lo, local_row2_hi, local_row3_lo, local_row3_hi,
        input  ready
    );
    modport sink (
        input  valid, bone_slot, parent_slot,
               local_row0_lo, local_row0_hi, local_row1_lo, local_row1_hi,
               local_row2_lo, local_row2_hi, local_row3_lo, local_row3_hi,
        output ready
    );
endinterface

interface bht_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] combined_row0_lo;
    logic [63:0] combined_row0_hi;
    logic [63:0] combined_row1_lo;
    logic [63:0] combined_row1_hi;
    logic [63:0] combined_row2_lo;
    logic [63:0] combined_row2_hi;
    logic [63:0] combined_row3_lo;
    logic [63:0] combined_row3_hi;
    logic [63:0] motion_dx_dy;
    logic [31:0] motion_dz;
    logic        motion_valid;

    modport source (
        output valid,
               combined_row0_lo, combined_row0_hi, combined_row1_lo, combined_row1_hi,
               combined_row2_lo, combined_row2_hi, combined_row3_lo, combined_row3_hi,
               motion_dx_dy, motion_dz, motion_valid,
        input  ready
    );
    modport sink (
        input  valid,
               combined_row0_lo, combined_row0_hi, combined_row1_lo, combined_row1_hi,
               combined_row2_lo, combined_row2_hi, combined_row3_lo, combined_row3_hi,
               motion_dx_dy, motion_dz, motion_valid,
        output ready
    );
endinterface

interface bht_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [bht_pkg::CFG_IDX_W-1:0] reg_index;
    logic [63:0]                   wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ===== src/bht_ram.sv =====
module bht_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== src/bht_fpu.sv =====
// float32 mul / add / sub, round to nearest even, full subnormal support.
// Three stages: operate, find leading one, shift + round + pack.
module bht_fpu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bht_pkg::t_fpu_req i_req,
    output logic              o_done,
    output logic [31:0]       o_result
);

    // ---- stage 1: unpack, multiply or align + add
    logic [7:0]  ea_f, eb_f, ea, eb;
    logic [23:0] ma, mb;
    logic        sa, sb, nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
    logic        spec;
    logic [31:0] spec_val;
    logic        sgn, zsgn;
    logic [47:0] mag;
    logic signed [11:0] q;
    logic        swap;
    logic [7:0]  e_big, e_sml, d;
    logic [23:0] m_big, m_sml;
    logic [4:0]  dcap;
    logic [53:0] wide;
    logic [26:0] a27, b27;
    logic [27:0] sum28;
    logic        s_big;

    always_comb begin
        ea_f   = i_req.a[30:23];
        eb_f   = i_req.b[30:23];
        sa     = i_req.a[31];
        sb     = i_req.b[31] ^ (i_req.op == bht_pkg::FOP_SUB);
        ea     = (ea_f == 8'd0) ? 8'd1 : ea_f;
        eb     = (eb_f == 8'd0) ? 8'd1 : eb_f;
        ma     = {ea_f != 8'd0, i_req.a[22:0]};
        mb     = {eb_f != 8'd0, i_req.b[22:0]};
        nan_a  = (ea_f == 8'hFF) && (i_req.a[22:0] != 23'd0);
        nan_b  = (eb_f == 8'hFF) && (i_req.b[22:0] != 23'd0);
        inf_a  = (ea_f == 8'hFF) && (i_req.a[22:0] == 23'd0);
        inf_b  = (eb_f == 8'hFF) && (i_req.b[22:0] == 23'd0);
        zero_a = (i_req.a[30:0] == 31'd0);
        zero_b = (i_req.b[30:0] == 31'd0);

        swap  = {eb, mb} > {ea, ma};
        e_big = swap ? eb : ea;
        e_sml = swap ? ea : eb;
        m_big = swap ? mb : ma;
        m_sml = swap ? ma : mb;
        s_big = swap ? sb : sa;
        d     = e_big - e_sml;
        dcap  = (d > 8'd31) ? 5'd31 : d[4:0];
        wide  = {m_sml, 3'b000, 27'd0} >> dcap;
        a27   = {m_big, 3'b000};
        b27   = wide[53:27] | {26'd0, |wide[26:0]};
        sum28 = (sa == sb) ? ({1'b0, a27} + {1'b0, b27}) : ({1'b0, a27} - {1'b0, b27});

        spec     = 1'b0;
        spec_val = '0;
        if (i_req.op == bht_pkg::FOP_MUL) begin
            sgn  = sa ^ sb;
            zsgn = sa ^ sb;
            mag  = ma * mb;
            q    = $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd300;
        end else begin
            sgn  = s_big;
            zsgn = sa & sb;
            mag  = {20'd0, sum28};
            q    = $signed({4'd0, e_big}) - 12'sd153;
        end

        // NaN from the first operand wins, always returned quiet
        if (nan_a) begin
            spec     = 1'b1;
            spec_val = i_req.a | bht_pkg::F32_QUIET;
        end else if (nan_b) begin
            spec     = 1'b1;
            spec_val = i_req.b | bht_pkg::F32_QUIET;
        end else if (i_req.op == bht_pkg::FOP_MUL) begin
            if ((inf_a && zero_b) || (inf_b && zero_a)) begin
                spec     = 1'b1;
                spec_val = bht_pkg::F32_QNAN;
            end else if (inf_a || inf_b) begin
                spec     = 1'b1;
                spec_val = {sa ^ sb, bht_pkg::F32_INF};
            end
        end else begin
            if (inf_a && inf_b && (sa != sb)) begin
                spec     = 1'b1;
                spec_val = bht_pkg::F32_QNAN;
            end else if (inf_a) begin
                spec     = 1'b1;
                spec_val = {sa, bht_pkg::F32_INF};
            end else if (inf_b) begin
                spec     = 1'b1;
                spec_val = {sb, bht_pkg::F32_INF};
            end
        end
    end

    logic               r1_valid, r1_spec, r1_sgn, r1_zsgn;
    logic [31:0]        r1_spec_val;
    logic [47:0]        r1_mag;
    logic signed [11:0] r1_q;

    // ---- stage 2: leading one and shift amount
    logic [5:0]         lead;
    logic signed [11:0] rp, rq, rsh;

    always_comb begin
        lead = '0;
        for (int k = 0; k < 48; k++) begin
            if (r1_mag[k]) begin
                lead = 6'(k);
            end
        end
        rp  = $signed({6'd0, lead}) - 12'sd23;
        rq  = -12'sd149 - r1_q;
        rsh = (rp > rq) ? rp : rq;
    end

    logic               r2_valid, r2_spec, r2_sgn, r2_zsgn, r2_zero;
    logic [31:0]        r2_spec_val;
    logic [47:0]        r2_mag;
    logic signed [11:0] r2_rsh, r2_eo;

    // ---- stage 3: shift, round, pack
    logic [11:0] nrsh;
    logic [5:0]  rc;
    logic [95:0] ext;
    logic [47:0] m_l;
    logic [23:0] m;
    logic        rbit, sticky, up;
    logic [24:0] m25;
    logic [34:0] packed_v;
    logic [31:0] res;

    always_comb begin
        nrsh = -r2_rsh;
        rc   = (r2_rsh > 12'sd63) ? 6'd63 : r2_rsh[5:0];
        ext  = {r2_mag, 48'd0} >> rc;
        m_l  = r2_mag << nrsh[4:0];
        if (r2_rsh[11]) begin
            m      = m_l[23:0];
            rbit   = 1'b0;
            sticky = 1'b0;
        end else begin
            m      = ext[71:48];
            rbit   = ext[47];
            sticky = |ext[46:0];
        end
        up       = rbit && (sticky || m[0]);
        m25      = {1'b0, m} + {24'd0, up};
        packed_v = {r2_eo, 23'd0} + {10'd0, m25};
        if (r2_spec) begin
            res = r2_spec_val;
        end else if (r2_zero) begin
            res = {r2_zsgn, 31'd0};
        end else if (packed_v[34:23] >= 12'd255) begin
            res = {r2_sgn, bht_pkg::F32_INF};
        end else begin
            res = {r2_sgn, packed_v[30:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            o_done   <= 1'b0;
        end else begin
            r1_valid <= i_req.start;
            r2_valid <= r1_valid;
            o_done   <= r2_valid;
        end
        r1_spec     <= spec;
        r1_spec_val <= spec_val;
        r1_sgn      <= sgn;
        r1_zsgn     <= zsgn;
        r1_mag      <= mag;
        r1_q        <= q;

        r2_spec     <= r1_spec;
        r2_spec_val <= r1_spec_val;
        r2_sgn      <= r1_sgn;
        r2_zsgn     <= r1_zsgn;
        r2_zero     <= (r1_mag == 48'd0);
        r2_mag      <= r1_mag;
        r2_rsh      <= rsh;
        r2_eo       <= r1_q + rsh + 12'sd149;

        o_result    <= res;
    end

endmodule

// ===== src/bone_hierarchy_transform.sv =====
// Bone hierarchy transform.
// Input channel i_in: one beat per bone (slot, parent slot, 4x4 float32 local
// matrix, row major, two floats per 64-bit word). Output channel o_out: one
// beat per bone with the combined matrix and the root-motion delta.
// Config channel i_cfg: pre-transform words 0..7, always ready; indexes
// beyond 7 are dropped. Write config only while the block is idle.
// A root (negative parent) gets PRE * L; any other bone gets L * P with P
// read back from the slot store, so parents must be sent before children.
// Children of slot 1 also produce root motion and have their translation
// row replaced by (0,0,0,1).
// Sequencing: i_in.ready is high only in idle. A bone takes up to 115 float ops
// (16 elements x (4 multiplies + 3 adds), then 3 subtracts for root motion),
// issued one at a time to one three-stage float unit, plus a parent read
// through the store's read port and a slot write through its write port.
// The finished beat sits in an output register; a stalled receiver holds
// the block in its final state until that register frees.
// Reset: pre-transform returns to identity, previous root translation to
// zero. The slot store is not cleared; reading a never-written parent slot
// gives undefined data.
module bone_hierarchy_transform #(
    parameter int MAX_BONES = bht_pkg::MAX_BONES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bht_in_if.sink    i_in,
    bht_out_if.source o_out,
    bht_cfg_if.sink   i_cfg
);

    localparam int SLOT_BITS = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
    localparam int ADDR_W    = SLOT_BITS + 3;
    localparam int DEPTH     = MAX_BONES * 8;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_LOAD   = 9'b000000010,
        ST_ISSUE  = 9'b000000100,
        ST_WAIT   = 9'b000001000,
        ST_MCLR   = 9'b000010000,
        ST_MISSUE = 9'b000100000,
        ST_MWAIT  = 9'b001000000,
        ST_STORE  = 9'b010000000,
        ST_OUT    = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    // pre-transform registers
    logic [63:0] r_pre [bht_pkg::NUM_CFG];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre <= bht_pkg::PRE_RESET;
        end else if (i_cfg.valid && (32'(i_cfg.reg_index) < bht_pkg::NUM_CFG)) begin
            r_pre[i_cfg.reg_index[2:0]] <= i_cfg.wdata;
        end
    end

    // operand matrices, results, root-motion state
    logic [31:0] r_amat [16];
    logic [31:0] r_bmat [16];
    logic [31:0] r_comb [16];
    logic [31:0] r_prev [3];
    logic [31:0] r_dlt  [3];
    logic [31:0] r_acc, r_prod;

    logic                 r_motion, r_slot_ok;
    logic [SLOT_BITS-1:0] r_slot, r_pslot;
    logic [3:0]           r_ld;
    logic [3:0]           r_elem;
    logic [2:0]           r_step;
    logic [1:0]           r_m;
    logic [2:0]           r_st;

    // output register
    logic        r_ovalid;
    logic [63:0] r_ocomb [8];
    logic [63:0] r_odxdy;
    logic [31:0] r_odz;
    logic        r_omv;

    // incoming beat decode
    logic [63:0]              in_words [8];
    logic                     in_root, in_motion, in_slot_ok, in_par_ok;
    logic [SLOT_BITS+7:0]     slot_wide, par_wide;
    logic                     accept;

    always_comb begin
        in_words[0] = i_in.local_row0_lo;
        in_words[1] = i_in.local_row0_hi;
        in_words[2] = i_in.local_row1_lo;
        in_words[3] = i_in.local_row1_hi;
        in_words[4] = i_in.local_row2_lo;
        in_words[5] = i_in.local_row2_hi;
        in_words[6] = i_in.local_row3_lo;
        in_words[7] = i_in.local_row3_hi;
        in_root     = i_in.parent_slot[8];
        in_motion   = !in_root && (i_in.parent_slot[7:0] == 8'd1);
        in_slot_ok  = 32'(i_in.bone_slot) < MAX_BONES;
        in_par_ok   = 32'(i_in.parent_slot[7:0]) < MAX_BONES;
        slot_wide   = {{SLOT_BITS{1'b0}}, i_in.bone_slot};
        par_wide    = {{SLOT_BITS{1'b0}}, i_in.parent_slot[7:0]};
    end

    assign i_in.ready = (r_state == ST_IDLE);
    assign accept     = i_in.valid && i_in.ready;

    // slot store
    logic              st_we;
    logic [ADDR_W-1:0] st_waddr, st_raddr;
    logic [63:0]       st_wdata, st_rdata;

    assign st_we    = (r_state == ST_STORE) && r_slot_ok;
    assign st_waddr = {r_slot, r_st};
    assign st_wdata = {r_comb[{r_st, 1'b1}], r_comb[{r_st, 1'b0}]};
    assign st_raddr = {r_pslot, r_ld[2:0]};

    bht_ram #(
        .WIDTH (64),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    // shared float unit
    bht_pkg::t_fpu_req fpu_req;
    logic              fpu_done;
    logic [31:0]       fpu_res;
    logic [2:0]        stp1;
    logic [1:0]        k_idx;
    logic [3:0]        mot_idx;

    always_comb begin
        stp1          = r_step + 3'd1;
        k_idx         = stp1[2:1];
        mot_idx       = 4'd12 + {2'd0, r_m};
        fpu_req.start = (r_state == ST_ISSUE) || (r_state == ST_MISSUE);
        if (r_state == ST_MISSUE) begin
            fpu_req.op = bht_pkg::FOP_SUB;
            fpu_req.a  = r_comb[mot_idx];
            fpu_req.b  = r_prev[r_m];
        end else if ((r_step == 3'd0) || r_step[0]) begin
            fpu_req.op = bht_pkg::FOP_MUL;
            fpu_req.a  = r_amat[{r_elem[3:2], k_idx}];
            fpu_req.b  = r_bmat[{k_idx, r_elem[1:0]}];
        end else begin
            fpu_req.op = bht_pkg::FOP_ADD;
            fpu_req.a  = r_acc;
            fpu_req.b  = r_prod;
        end
    end

    bht_fpu u_fpu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (fpu_req),
        .o_done   (fpu_done),
        .o_result (fpu_res)
    );

    // translation row is exactly (0,0,0,1), with -0 equal to 0
    logic zero_trans;
    assign zero_trans = (r_comb[12][30:0] == 31'd0) && (r_comb[13][30:0] == 31'd0) &&
                        (r_comb[14][30:0] == 31'd0) && (r_comb[15] == bht_pkg::F32_ONE);

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = (!in_root && in_par_ok) ? ST_LOAD : ST_ISSUE;
                end
            end
            ST_LOAD: begin
                if (r_ld == 4'd8) begin
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: n_state = ST_WAIT;
            ST_WAIT: begin
                if (fpu_done) begin
                    if ((r_step == 3'd6) && (r_elem == 4'd15)) begin
                        n_state = r_motion ? ST_MCLR : ST_STORE;
                    end else begin
                        n_state = ST_ISSUE;
                    end
                end
            end
            ST_MCLR:   n_state = ST_MISSUE;
            ST_MISSUE: n_state = ST_MWAIT;
            ST_MWAIT: begin
                if (fpu_done) begin
                    n_state = (r_m == 2'd2) ? ST_STORE : ST_MISSUE;
                end
            end
            ST_STORE: begin
                if (r_st == 3'd7) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_ovalid || o_out.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_prev   <= '{default: '0};
            r_ld     <= '0;
            r_elem   <= '0;
            r_step   <= '0;
            r_m      <= '0;
            r_st     <= '0;
        end else begin
            r_state <= n_state;
            // ST_OUT reloads the register itself when it frees
            if (r_ovalid && o_out.ready && (r_state != ST_OUT)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    r_ld   <= '0;
                    r_elem <= '0;
                    r_step <= '0;
                    r_st   <= '0;
                    if (accept) begin
                        r_motion  <= in_motion;
                        r_slot_ok <= in_slot_ok;
                        r_slot    <= slot_wide[SLOT_BITS-1:0];
                        r_pslot   <= par_wide[SLOT_BITS-1:0];
                        for (int w = 0; w < 8; w++) begin
                            if (in_root) begin
                                r_amat[2*w]   <= r_pre[w][31:0];
                                r_amat[2*w+1] <= r_pre[w][63:32];
                                r_bmat[2*w]   <= in_words[w][31:0];
                                r_bmat[2*w+1] <= in_words[w][63:32];
                            end else begin
                                r_amat[2*w]   <= in_words[w][31:0];
                                r_amat[2*w+1] <= in_words[w][63:32];
                                r_bmat[2*w]   <= '0;
                                r_bmat[2*w+1] <= '0;
                            end
                        end
                    end
                end
                ST_LOAD: begin
                    r_ld <= r_ld + 4'd1;
                    // read data arrives the cycle after its address
                    if (r_ld != 4'd0) begin
                        r_bmat[{r_ld[2:0] - 3'd1, 1'b0}] <= st_rdata[31:0];
                        r_bmat[{r_ld[2:0] - 3'd1, 1'b1}] <= st_rdata[63:32];
                    end
                end
                ST_WAIT: begin
                    if (fpu_done) begin
                        if (r_step[0] && (r_step != 3'd0)) begin
                            r_prod <= fpu_res;
                        end else begin
                            r_acc <= fpu_res;
                        end
                        if (r_step == 3'd6) begin
                            r_comb[r_elem] <= fpu_res;
                            r_step         <= '0;
                            r_elem         <= r_elem + 4'd1;
                        end else begin
                            r_step <= r_step + 3'd1;
                        end
                    end
                end
                ST_MCLR: begin
                    r_m <= '0;
                    if (zero_trans) begin
                        r_prev <= '{default: '0};
                    end
                end
                ST_MWAIT: begin
                    if (fpu_done) begin
                        r_dlt[r_m] <= fpu_res;
                        r_m        <= r_m + 2'd1;
                        if (r_m == 2'd2) begin
                            r_prev[0]  <= r_comb[12];
                            r_prev[1]  <= r_comb[13];
                            r_prev[2]  <= r_comb[14];
                            r_comb[12] <= '0;
                            r_comb[13] <= '0;
                            r_comb[14] <= '0;
                            r_comb[15] <= bht_pkg::F32_ONE;
                        end
                    end
                end
                ST_STORE: r_st <= r_st + 3'd1;
                ST_OUT: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_ovalid <= 1'b1;
                        for (int w = 0; w < 8; w++) begin
                            r_ocomb[w] <= {r_comb[2*w+1], r_comb[2*w]};
                        end
                        r_odxdy <= r_motion ? {r_dlt[1], r_dlt[0]} : 64'd0;
                        r_odz   <= r_motion ? r_dlt[2] : 32'd0;
                        r_omv   <= r_motion;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out.valid            = r_ovalid;
    assign o_out.combined_row0_lo = r_ocomb[0];
    assign o_out.combined_row0_hi = r_ocomb[1];
    assign o_out.combined_row1_lo = r_ocomb[2];
    assign o_out.combined_row1_hi = r_ocomb[3];
    assign o_out.combined_row2_lo = r_ocomb[4];
    assign o_out.combined_row2_hi = r_ocomb[5];
    assign o_out.combined_row3_lo = r_ocomb[6];
    assign o_out.combined_row3_hi = r_ocomb[7];
    assign o_out.motion_dx_dy     = r_odxdy;
    assign o_out.motion_dz        = r_odz;
    assign o_out.motion_valid     = r_omv;

endmodule

// ===== dv/bone_hierarchy_transform_tb.sv =====
module bone_hierarchy_transform_tb;
    import bht_pkg::*;

    localparam int LIMIT_CYCLES = 4_000_000;
    localparam int HOLD_CYCLES  = 3000;
    localparam int DRAIN_CYCLES = 600;    // a bit over one bone's time through the block

    // pre-transform register indexes
    typedef enum int {
        PRE_ROW0_LO = 0, PRE_ROW0_HI, PRE_ROW1_LO, PRE_ROW1_HI,
        PRE_ROW2_LO, PRE_ROW2_HI, PRE_ROW3_LO, PRE_ROW3_HI
    } t_pre_reg;

    typedef logic [15:0][31:0] t_mat;    // element 0 = m11, row major

    typedef struct {
        logic [7:0]        slot;
        logic signed [8:0] parent;
        logic [7:0][63:0]  rows;
    } t_bone;

    typedef struct packed {
        logic [7:0][63:0] rows;
        logic [63:0]      dxdy;
        logic [31:0]      dz;
        logic             mv;
    } t_pose;

    typedef struct {
        t_bone bone;
        bit    literal;    // expected pose typed in below
        t_pose pose;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    bht_in_if  in_if ();
    bht_out_if out_if ();
    bht_cfg_if cfg_if ();

    bone_hierarchy_transform DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // predictor state
    logic [63:0] pre_words [8];
    t_mat        slot_mat [256];
    bit          slot_written [256];
    int          written_slots [$];
    logic [31:0] prev_xyz [3];

    t_pose pose_q [$];
    int    fail_cnt;
    int    cycle_cnt;
    bit    calm;          // no random idling on either side
    bit    start_hold;    // ask the receiver for a long hold-off
    int    hold_left;
    t_dir_row dir_rows [$];

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ---------------- float32 arithmetic, RNE, x86-style NaN handling ----------------

    function automatic bit is_nan(logic [31:0] f);
        return f[30:23] == 8'hFF && f[22:0] != 0;
    endfunction

    function automatic real f32_to_real(logic [31:0] f);
        real r;
        logic [63:0] d;
        if (f[30:23] == 8'h00)
            r = real'(f[22:0]) * $bitstoreal({1'b0, 11'd874, 52'd0});    // 2^-149
        else if (f[30:23] == 8'hFF)
            r = $bitstoreal({1'b0, 11'h7FF, 52'd0});
        else
            r = $bitstoreal({1'b0, 11'(f[30:23]) + 11'd896, f[22:0], 29'd0});
        d = $realtobits(r);
        d[63] = f[31];
        return $bitstoreal(d);
    endfunction

    // double -> float32; double rounding is harmless for single ops at 53 bits
    function automatic logic [31:0] real_to_f32(real r);
        logic [63:0] d, mant, q, rem, half;
        logic [31:0] mag;
        int ue, sh;
        d = $realtobits(r);
        if (d[62:52] == 11'h7FF)
            return (d[51:0] != 0) ? F32_QNAN : {d[63], 8'hFF, 23'd0};
        if (d[62:52] == 11'h000)
            return {d[63], 31'd0};
        ue = int'(d[62:52]) - 1023;
        if (ue > 127)
            return {d[63], F32_INF};
        mant = {11'd0, 1'b1, d[51:0]};
        sh = (ue >= -126) ? 29 : (-97 - ue);
        if (sh > 60)
            return {d[63], 31'd0};
        q    = mant >> sh;
        rem  = mant & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0]))
            q = q + 1;
        if (ue >= -126) begin
            mag = (32'(ue + 127) << 23) + 32'(q) - 32'h0080_0000;
            if (mag >= {1'b0, F32_INF})
                mag = {1'b0, F32_INF};
        end else begin
            mag = 32'(q);    // may carry into the smallest normal
        end
        return {d[63], mag[30:0]};
    endfunction

    function automatic logic [31:0] fp_op(t_fop op, logic [31:0] a, logic [31:0] b);
        real ra, rb, rr;
        if (is_nan(a)) return a | F32_QUIET;
        if (is_nan(b)) return b | F32_QUIET;
        ra = f32_to_real(a);
        rb = f32_to_real(b);
        case (op)
            FOP_MUL: rr = ra * rb;
            FOP_ADD: rr = ra + rb;
            default: rr = ra - rb;
        endcase
        if (rr != rr) return F32_QNAN;    // inf*0, inf-inf
        return real_to_f32(rr);
    endfunction

    // ---------------- bone transform predictor ----------------

    function automatic t_mat words_to_mat(logic [7:0][63:0] w);
        t_mat m;
        for (int i = 0; i < 8; i++) begin
            m[2*i]   = w[i][31:0];
            m[2*i+1] = w[i][63:32];
        end
        return m;
    endfunction

    function automatic logic [7:0][63:0] mat_to_words(t_mat m);
        logic [7:0][63:0] w;
        for (int i = 0; i < 8; i++) w[i] = {m[2*i+1], m[2*i]};
        return w;
    endfunction

    // sum order ((p1 + p2) + p3) + p4, each step rounded
    function automatic t_mat mat_product(t_mat a, t_mat b);
        t_mat r;
        logic [31:0] s;
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++) begin
                s = fp_op(FOP_MUL, a[i*4], b[j]);
                for (int k = 1; k < 4; k++)
                    s = fp_op(FOP_ADD, s, fp_op(FOP_MUL, a[i*4+k], b[k*4+j]));
                r[i*4+j] = s;
            end
        return r;
    endfunction

    function automatic t_pose transform_bone(t_bone bn);
        t_mat  loc, comb;
        t_pose p;
        bit    motion;
        loc = words_to_mat(bn.rows);
        motion = (bn.parent == 9'sd1);
        if (bn.parent < 0) begin
            comb = mat_product(words_to_mat({pre_words[7], pre_words[6], pre_words[5],
                                             pre_words[4], pre_words[3], pre_words[2],
                                             pre_words[1], pre_words[0]}), loc);
        end else begin
            comb = mat_product(loc, slot_mat[bn.parent[7:0]]);
        end
        p.dxdy = '0;
        p.dz   = '0;
        p.mv   = 1'b0;
        if (motion) begin
            // translation row back at origin: restart root motion (-0 counts as 0)
            if (comb[12][30:0] == 0 && comb[13][30:0] == 0 && comb[14][30:0] == 0 &&
                comb[15] == F32_ONE)
                for (int i = 0; i < 3; i++) prev_xyz[i] = '0;
            p.dxdy = {fp_op(FOP_SUB, comb[13], prev_xyz[1]),
                      fp_op(FOP_SUB, comb[12], prev_xyz[0])};
            p.dz   = fp_op(FOP_SUB, comb[14], prev_xyz[2]);
            p.mv   = 1'b1;
            for (int i = 0; i < 3; i++) prev_xyz[i] = comb[12+i];
            comb[12] = '0;
            comb[13] = '0;
            comb[14] = '0;
            comb[15] = F32_ONE;
        end
        slot_mat[bn.slot] = comb;
        if (!slot_written[bn.slot]) begin
            slot_written[bn.slot] = 1'b1;
            written_slots.push_back(bn.slot);
        end
        p.rows = mat_to_words(comb);
        return p;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic t_mat ident_mat();
        t_mat m;
        m = '0;
        m[0]  = F32_ONE;
        m[5]  = F32_ONE;
        m[10] = F32_ONE;
        m[15] = F32_ONE;
        return m;
    endfunction

    function automatic logic [31:0] rand_f32();
        logic [31:0] f;
        int pick;
        pick = $urandom_range(0, 49);
        f = $urandom;
        if (pick < 5)       f = {f[31], 31'd0};
        else if (pick < 10) f = {f[31], F32_ONE[30:0]};
        else if (pick > 48) f = f;    // raw bits: NaN, inf, subnormal
        else                f[30:23] = 8'($urandom_range(118, 136));
        return f;
    endfunction

    function automatic t_bone rand_bone();
        t_bone bn;
        t_mat  m;
        int    r;
        bn.slot = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 15)) : 8'($urandom);
        r = $urandom_range(0, 99);
        if (r < 22 || written_slots.size() == 0)
            bn.parent = {1'b1, 8'($urandom)};    // any negative parent is a root
        else if (r < 50 && slot_written[1])
            bn.parent = 9'sd1;
        else
            bn.parent = {1'b0, 8'(written_slots[$urandom_range(0, written_slots.size()-1)])};
        for (int i = 0; i < 16; i++) m[i] = rand_f32();
        if ($urandom_range(0, 11) == 0) begin
            m[12] = '0; m[13] = '0; m[14] = '0; m[15] = F32_ONE;
        end
        bn.rows = mat_to_words(m);
        return bn;
    endfunction

    // one beat on the input channel; valid stays high on return
    task automatic send_bone(t_bone bn, bit literal, t_pose lit_pose);
        t_pose p;
        while (!calm && $urandom_range(0, 99) < 15) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.bone_slot     <= bn.slot;
        in_if.parent_slot   <= bn.parent;
        in_if.local_row0_lo <= bn.rows[0];
        in_if.local_row0_hi <= bn.rows[1];
        in_if.local_row1_lo <= bn.rows[2];
        in_if.local_row1_hi <= bn.rows[3];
        in_if.local_row2_lo <= bn.rows[4];
        in_if.local_row2_hi <= bn.rows[5];
        in_if.local_row3_lo <= bn.rows[6];
        in_if.local_row3_hi <= bn.rows[7];
        do @(posedge i_clk); while (!in_if.ready);
        p = transform_bone(bn);
        pose_q.push_back(literal ? lit_pose : p);
    endtask

    task automatic run_random(int n);
        t_pose unused;
        unused = '0;
        repeat (n) send_bone(rand_bone(), 1'b0, unused);
        in_if.valid <= 1'b0;
    endtask

    // block idle: every pose back, then its internal tail
    task automatic drain();
        while (pose_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_pre(t_pre_reg idx, logic [63:0] val);
        cfg_if.valid     <= 1'b1;
        cfg_if.reg_index <= CFG_IDX_W'(idx);
        cfg_if.wdata     <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        pre_words[idx] = val;
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic add_row(logic [7:0] slot, logic signed [8:0] parent, t_mat loc,
                           bit literal, t_pose pose);
        t_dir_row d;
        d.bone.slot   = slot;
        d.bone.parent = parent;
        d.bone.rows   = mat_to_words(loc);
        d.literal     = literal;
        d.pose        = pose;
        dir_rows.push_back(d);
    endtask

    task automatic build_directed();
        t_mat  m;
        t_pose id_pose, pz;
        id_pose      = '0;
        id_pose.rows = mat_to_words(ident_mat());
        pz           = '0;
        // identity pre-transform after reset
        add_row(8'd0, -9'sd1, ident_mat(), 1'b1, id_pose);
        add_row(8'd1, -9'sd1, ident_mat(), 1'b1, id_pose);
        // child of slot 1 at origin: previous translation cleared, zero delta
        id_pose.mv = 1'b1;
        add_row(8'd2, 9'sd1, ident_mat(), 1'b1, id_pose);
        // translation (1,2,3): delta (1,2,3), then (0,0,0) when repeated
        m = ident_mat();
        m[12] = 32'h3F80_0000; m[13] = 32'h4000_0000; m[14] = 32'h4040_0000;
        id_pose.dxdy = {32'h4000_0000, 32'h3F80_0000};
        id_pose.dz   = 32'h4040_0000;
        add_row(8'd3, 9'sd1, m, 1'b1, id_pose);
        id_pose.dxdy = '0;
        id_pose.dz   = '0;
        add_row(8'd3, 9'sd1, m, 1'b1, id_pose);
        // zero local times identity parent
        add_row(8'd4, 9'sd0, '0, 1'b1, pz);
        // most negative parent, all-ones local (NaN everywhere)
        add_row(8'd255, -9'sd256, '1, 1'b0, pz);
        // parent is own slot, old value read first
        m = ident_mat();
        m[1] = 32'h4080_0000;
        add_row(8'd255, 9'sd255, m, 1'b0, pz);
        add_row(8'd0, 9'sd0, m, 1'b0, pz);
        // infinities against zeros
        m = ident_mat();
        m[0] = {1'b0, F32_INF}; m[6] = {1'b1, F32_INF}; m[12] = 32'h7F7F_FFFF;
        add_row(8'd5, -9'sd1, m, 1'b0, pz);
        // -0 translation still counts as origin
        m = ident_mat();
        m[12] = 32'h8000_0000; m[13] = 32'h8000_0000; m[14] = 32'h8000_0000;
        add_row(8'd6, 9'sd1, m, 1'b0, pz);
        // subnormals and overflow
        m = ident_mat();
        m[0] = 32'h0000_0001; m[5] = 32'h007F_FFFF; m[10] = 32'h7F7F_FFFF;
        m[12] = 32'h7F00_0000; m[13] = 32'h8080_0000;
        add_row(8'd7, -9'sd1, m, 1'b0, pz);
        add_row(8'd8, 9'sd7, m, 1'b0, pz);
        add_row(8'd9, 9'sd1, m, 1'b0, pz);
        // child of a child of slot 1 (no root motion)
        add_row(8'd10, 9'sd2, m, 1'b0, pz);
    endtask

    // ---------------- receiver and checker ----------------

    always @(posedge i_clk) begin
        t_pose exp_p, got;
        if (in_if.valid === 1'bx) ;    // keeps the block free of empty-begin warnings
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.rows = {out_if.combined_row3_hi, out_if.combined_row3_lo,
                        out_if.combined_row2_hi, out_if.combined_row2_lo,
                        out_if.combined_row1_hi, out_if.combined_row1_lo,
                        out_if.combined_row0_hi, out_if.combined_row0_lo};
            got.dxdy = out_if.motion_dx_dy;
            got.dz   = out_if.motion_dz;
            got.mv   = out_if.motion_valid;
            if (pose_q.size() == 0) begin
                $display("%0t: pose beat with nothing expected", $time);
                fail_cnt++;
            end else begin
                exp_p = pose_q.pop_front();
                for (int i = 0; i < 8; i++)
                    if (got.rows[i] !== exp_p.rows[i]) begin
                        $display("%0t: combined word %0d expected %h got %h",
                                 $time, i, exp_p.rows[i], got.rows[i]);
                        fail_cnt++;
                    end
                if (got.dxdy !== exp_p.dxdy) begin
                    $display("%0t: motion_dx_dy expected %h got %h",
                             $time, exp_p.dxdy, got.dxdy);
                    fail_cnt++;
                end
                if (got.dz !== exp_p.dz) begin
                    $display("%0t: motion_dz expected %h got %h", $time, exp_p.dz, got.dz);
                    fail_cnt++;
                end
                if (got.mv !== exp_p.mv) begin
                    $display("%0t: motion_valid expected %b got %b", $time, exp_p.mv, got.mv);
                    fail_cnt++;
                end
            end
        end
        // long hold-off while the sender keeps pushing
        if (start_hold) begin
            start_hold = 1'b0;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= calm || ($urandom_range(0, 99) >= 15);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ---------------- main sequence ----------------

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        in_if.valid    = 1'b0;
        in_if.bone_slot     = '0;
        in_if.parent_slot   = '0;
        in_if.local_row0_lo = '0;
        in_if.local_row0_hi = '0;
        in_if.local_row1_lo = '0;
        in_if.local_row1_hi = '0;
        in_if.local_row2_lo = '0;
        in_if.local_row2_hi = '0;
        in_if.local_row3_lo = '0;
        in_if.local_row3_hi = '0;
        out_if.ready     = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.reg_index = '0;
        cfg_if.wdata     = '0;
        fail_cnt   = 0;
        cycle_cnt  = 0;
        calm       = 1'b0;
        start_hold = 1'b0;
        hold_left  = 0;
        for (int i = 0; i < NUM_CFG; i++) pre_words[i] = PRE_RESET[i];
        for (int i = 0; i < 3; i++) prev_xyz[i] = '0;
        for (int i = 0; i < 256; i++) begin
            slot_written[i] = 1'b0;
            slot_mat[i]     = '0;
        end
        build_directed();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table under the reset pre-transform
        foreach (dir_rows[i])
            send_bone(dir_rows[i].bone, dir_rows[i].literal, dir_rows[i].pose);
        in_if.valid <= 1'b0;
        run_random(280);
        drain();

        // random, mostly well-scaled pre-transform
        for (int r = PRE_ROW0_LO; r <= PRE_ROW3_HI; r++)
            write_pre(t_pre_reg'(r), {rand_f32(), rand_f32()});
        run_random(280);
        drain();

        // extremes: all zero, then all ones (NaN)
        for (int r = PRE_ROW0_LO; r <= PRE_ROW3_HI; r++) write_pre(t_pre_reg'(r), '0);
        run_random(140);
        drain();
        for (int r = PRE_ROW0_LO; r <= PRE_ROW3_HI; r++) write_pre(t_pre_reg'(r), '1);
        run_random(140);
        drain();

        // back to identity, no idling, with one long receiver hold-off
        for (int r = PRE_ROW0_LO; r <= PRE_ROW3_HI; r++)
            write_pre(t_pre_reg'(r), PRE_RESET[r]);
        calm       = 1'b1;
        start_hold = 1'b1;
        run_random(200);
        calm = 1'b0;
        run_random(200);

        while (pose_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
